>>> src/reb_pkg.sv
package reb_pkg;

   localparam int unsigned COUNT_W   = 10;
   localparam int unsigned TIME_W    = 32;
   localparam int unsigned CFG_W     = 16;
   localparam int unsigned STEPS_W   = 8;
   localparam int unsigned CSR_IDX_W = 8;

   // register indexes on the csr channel
   localparam logic [CSR_IDX_W-1:0] REG_DEBOUNCE_MS = 8'd0;
   localparam logic [CSR_IDX_W-1:0] REG_HOLD_MS     = 8'd1;

   localparam logic [CFG_W-1:0] DEBOUNCE_MS_RESET = 16'd50;
   localparam logic [CFG_W-1:0] HOLD_MS_RESET     = 16'd1000;

   localparam logic signed [COUNT_W-1:0] COUNT_MAX = 10'sd511;
   localparam logic signed [COUNT_W-1:0] COUNT_MIN = -10'sd511;

   // count change indexed by {previous ab, current ab}
   localparam logic signed [1:0] QUAD_TABLE [16] = '{
       2'sd0, -2'sd1,  2'sd1,  2'sd0,
       2'sd1,  2'sd0,  2'sd0, -2'sd1,
      -2'sd1,  2'sd0,  2'sd0,  2'sd1,
       2'sd0,  2'sd1, -2'sd1,  2'sd0
   };

endpackage

>>> src/reb_if.sv
interface reb_req_if;
   logic valid;
   logic ready;
   logic pin_a;
   logic pin_b;
   logic pin_button;
   logic ms_tick;
   logic ack_steps;
   logic ack_press;

   modport source (output valid, pin_a, pin_b, pin_button, ms_tick, ack_steps, ack_press,
                   input ready);
   modport sink (input valid, pin_a, pin_b, pin_button, ms_tick, ack_steps, ack_press,
                 output ready);
endinterface

interface reb_rsp_if;
   import reb_pkg::*;
   logic                      valid;
   logic                      ready;
   logic signed [STEPS_W-1:0] steps;
   logic                      press_event;
   logic                      held_event;
   logic                      button_down;

   modport source (output valid, steps, press_event, held_event, button_down,
                   input ready);
   modport sink (input valid, steps, press_event, held_event, button_down,
                 output ready);
endinterface

interface reb_csr_if;
   import reb_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [CFG_W-1:0]     data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

>>> src/rotary_encoder_with_button_core.sv
// Quadrature encoder and push-button front end. Every request transaction carries one sample
// of the A, B and active-low button pins plus a millisecond tick and two acknowledge flags, and
// produces exactly one response transaction in the next cycle. A new request is taken every
// clock as long as the previous response is taken in the same cycle; while a finished response
// waits for rsp ready, the request side is held off. While rsp ready stays high, the sustained
// rate is one transaction per cycle and is set by the one register stage that updates all
// encoder and button state on acceptance. The count saturates at +/-511 quadrature transitions;
// acknowledged steps report whole detents (four transitions) rounded toward zero and keep the
// remainder. A press is taken only when more than debounce_ms ticks have passed since the last
// taken press; holding longer than hold_ms raises a one-shot hold flag and suppresses the
// short-press event on release. The csr channel is always ready; writes to unknown indexes are
// dropped.
module rotary_encoder_with_button_core (
   input  logic clock,
   input  logic reset,
   reb_req_if.sink   req_chan,
   reb_rsp_if.source rsp_chan,
   reb_csr_if.sink   csr_chan
);
   import reb_pkg::*;

   // configuration
   logic [CFG_W-1:0] debounce_ms_ff;
   logic [CFG_W-1:0] hold_ms_ff;

   // state
   logic [1:0]                prev_ab_ff, prev_ab_in;
   logic                      primed_ff, primed_in;
   logic signed [COUNT_W-1:0] quad_count_ff, quad_count_in;
   logic                      prev_button_ff, prev_button_in;
   logic [TIME_W-1:0]         now_ms_ff, now_ms_in;
   logic [TIME_W-1:0]         last_accept_ms_ff, last_accept_ms_in;
   logic [TIME_W-1:0]         press_start_ms_ff, press_start_ms_in;
   logic                      pressed_ff, pressed_in;
   logic                      hold_flagged_ff, hold_flagged_in;
   logic                      press_pending_ff, press_pending_in;

   // response register
   logic                      rsp_valid_ff;
   logic signed [STEPS_W-1:0] rsp_steps_ff, rsp_steps_in;
   logic                      rsp_press_ff, rsp_held_ff, rsp_held_in, rsp_down_ff;

   logic                      req_fire;
   logic [3:0]                quad_idx;
   logic signed [1:0]         quad_delta;
   logic signed [COUNT_W:0]   count_sum;
   logic signed [COUNT_W-1:0] count_sat;
   logic signed [COUNT_W-1:0] count_bias;
   logic signed [COUNT_W-1:0] detents;
   logic                      btn_fall, btn_rise, press_take;
   logic [TIME_W-1:0]         since_accept, since_start;
   logic                      hold_hit;
   logic                      pressed_mid, hold_mid, pending_mid;

   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign csr_chan.ready = 1'b1;

   always_comb begin
      now_ms_in = req_chan.ms_tick ? now_ms_ff + 32'd1 : now_ms_ff;

      // quadrature
      prev_ab_in = {req_chan.pin_a, req_chan.pin_b};
      primed_in  = 1'b1;
      quad_idx   = {prev_ab_ff, prev_ab_in};
      quad_delta = primed_ff ? QUAD_TABLE[quad_idx] : 2'sd0;
      count_sum  = {quad_count_ff[COUNT_W-1], quad_count_ff}
                   + {{(COUNT_W-1){quad_delta[1]}}, quad_delta};
      if (count_sum > $signed({COUNT_MAX[COUNT_W-1], COUNT_MAX})) begin
         count_sat = COUNT_MAX;
      end else if (count_sum < $signed({COUNT_MIN[COUNT_W-1], COUNT_MIN})) begin
         count_sat = COUNT_MIN;
      end else begin
         count_sat = count_sum[COUNT_W-1:0];
      end

      // button edges and debounce
      btn_fall          = prev_button_ff && !req_chan.pin_button;
      btn_rise          = !prev_button_ff && req_chan.pin_button;
      prev_button_in    = req_chan.pin_button;
      since_accept      = now_ms_in - last_accept_ms_ff;
      press_take        = btn_fall && (since_accept > {16'd0, debounce_ms_ff});
      last_accept_ms_in = press_take ? now_ms_in : last_accept_ms_ff;
      press_start_ms_in = press_take ? now_ms_in : press_start_ms_ff;
      pressed_mid       = pressed_ff;
      hold_mid          = hold_flagged_ff;
      pending_mid       = press_pending_ff;
      if (press_take) begin
         pressed_mid = 1'b1;
         hold_mid    = 1'b0;
      end else if (btn_rise && pressed_ff) begin
         pressed_mid = 1'b0;
         if (!hold_flagged_ff) begin
            pending_mid = 1'b1;
         end
      end

      // a fresh press is excluded by !press_take, so it can never hit the hold here
      since_start     = now_ms_in - press_start_ms_ff;
      hold_hit        = pressed_mid && !hold_mid && !press_take
                        && (since_start > {16'd0, hold_ms_ff});
      pressed_in      = pressed_mid;
      hold_flagged_in = hold_mid || hold_hit;
      rsp_held_in     = hold_hit;

      // detents, truncated toward zero
      count_bias = count_sat[COUNT_W-1] ? count_sat + 10'sd3 : count_sat;
      detents    = req_chan.ack_steps ? (count_bias >>> 2) : 10'sd0;
      quad_count_in = count_sat - {detents[COUNT_W-3:0], 2'b00};
      rsp_steps_in  = detents[STEPS_W-1:0];

      press_pending_in = pending_mid && !req_chan.ack_press;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ms_ff <= DEBOUNCE_MS_RESET;
         hold_ms_ff     <= HOLD_MS_RESET;
      end else if (csr_chan.valid && csr_chan.ready) begin
         unique case (csr_chan.index)
            REG_DEBOUNCE_MS: debounce_ms_ff <= csr_chan.data;
            REG_HOLD_MS:     hold_ms_ff     <= csr_chan.data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ab_ff        <= '0;
         primed_ff         <= 1'b0;
         quad_count_ff     <= '0;
         prev_button_ff    <= 1'b1;
         now_ms_ff         <= '0;
         last_accept_ms_ff <= '0;
         press_start_ms_ff <= '0;
         pressed_ff        <= 1'b0;
         hold_flagged_ff   <= 1'b0;
         press_pending_ff  <= 1'b0;
      end else if (req_fire) begin
         prev_ab_ff        <= prev_ab_in;
         primed_ff         <= primed_in;
         quad_count_ff     <= quad_count_in;
         prev_button_ff    <= prev_button_in;
         now_ms_ff         <= now_ms_in;
         last_accept_ms_ff <= last_accept_ms_in;
         press_start_ms_ff <= press_start_ms_in;
         pressed_ff        <= pressed_in;
         hold_flagged_ff   <= hold_flagged_in;
         press_pending_ff  <= press_pending_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_steps_ff <= rsp_steps_in;
         rsp_press_ff <= pending_mid;
         rsp_held_ff  <= rsp_held_in;
         rsp_down_ff  <= pressed_in;
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.steps       = rsp_steps_ff;
   assign rsp_chan.press_event = rsp_press_ff;
   assign rsp_chan.held_event  = rsp_held_ff;
   assign rsp_chan.button_down = rsp_down_ff;

`ifndef SYNTHESIS
   a_count_in_range: assert property (@(posedge clock) disable iff (reset)
      quad_count_ff <= COUNT_MAX && quad_count_ff >= COUNT_MIN)
      else $error("quadrature count outside saturation limits");

   a_fire_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> rsp_valid_ff)
      else $error("accepted transaction produced no response");

   a_held_while_down: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_held_ff) |-> rsp_down_ff)
      else $error("hold event without a press in progress");

   a_hold_needs_press: assert property (@(posedge clock) disable iff (reset)
      (req_fire && rsp_held_in) |=> (pressed_ff && hold_flagged_ff))
      else $error("hold flagged without pressed state");
`endif

endmodule
